// ===== hw/rtl/prime_lister_trial_division_assert.svh =====
// assertion macros for the prime lister
`ifndef PRIME_LISTER_TRIAL_DIVISION_ASSERT_SVH
`define PRIME_LISTER_TRIAL_DIVISION_ASSERT_SVH

// same-cycle implication
`define PLTD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pltd assertion failed");

// next-cycle implication
`define PLTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pltd assertion failed");

`endif

// ===== hw/rtl/pltd_pkg.sv =====
`timescale 1ns / 1ps

package pltd_pkg;

   localparam int FIELD_WIDTH = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_TEST,
      ST_DIVIDE,
      ST_REMAIN,
      ST_PRIME,
      ST_NEXT
   } state_type;

   typedef struct packed {
      logic load;
      logic dec_cand;
      logic init_div;
      logic inc_div;
      logic rem_start;
      logic rem_step;
      logic emit_prime;
      logic emit_bad;
   } cmd_type;

   typedef struct packed {
      logic cand_lt2;
      logic cand_is_two;
      logic div_eq_cand;
      logic rem_zero;
      logic rem_last;
   } status_type;

endpackage

// ===== hw/rtl/prime_lister_trial_division.sv =====
`timescale 1ns / 1ps
// each trial divisor runs the bit-serial remainder loop; a beat is strobed the cycle after its prime
// one limit at a time: start is taken only in idle, once the last beat of a list is out
// the receiver cannot stall: every beat shows for exactly one cycle
// synchronous reset clears the controller and the strobe; no clearing pass

module prime_lister_trial_division #(
   parameter int VALUE_WIDTH = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [pltd_pkg::FIELD_WIDTH-1:0] req_limit,
   output logic                             rsp_strobe,
   output logic [pltd_pkg::FIELD_WIDTH-1:0] rsp_prime_value,
   output logic                             rsp_is_last,
   output logic                             rsp_bad_limit
);

`include "prime_lister_trial_division_assert.svh"

   pltd_pkg::cmd_type    cmd;
   pltd_pkg::status_type status;

   pltd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   pltd_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_limit       (req_limit),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_prime_value (rsp_prime_value),
      .rsp_is_last     (rsp_is_last),
      .rsp_bad_limit   (rsp_bad_limit)
   );

   `PLTD_ASSERT_NOW(a_bad_is_last, clock, reset, rsp_strobe && rsp_bad_limit, rsp_is_last)
   `PLTD_ASSERT_NOW(a_last_is_two, clock, reset, rsp_strobe && !rsp_bad_limit, rsp_is_last == (rsp_prime_value == 8'd2))
   `PLTD_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `PLTD_ASSERT_NOW(a_last_idle, clock, reset, rsp_strobe && rsp_is_last, !busy)

endmodule

// ===== hw/rtl/pltd_ctrl.sv =====
`timescale 1ns / 1ps

module pltd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  pltd_pkg::status_type   status,
   output pltd_pkg::cmd_type      cmd
);

   pltd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pltd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pltd_pkg::ST_IDLE: begin
            if (start) state_in = pltd_pkg::ST_CHECK;
         end
         pltd_pkg::ST_CHECK: begin
            state_in = status.cand_lt2 ? pltd_pkg::ST_IDLE : pltd_pkg::ST_TEST;
         end
         pltd_pkg::ST_TEST: begin
            state_in = status.div_eq_cand ? pltd_pkg::ST_PRIME : pltd_pkg::ST_DIVIDE;
         end
         pltd_pkg::ST_DIVIDE: begin
            if (status.rem_last) state_in = pltd_pkg::ST_REMAIN;
         end
         pltd_pkg::ST_REMAIN: begin
            state_in = status.rem_zero ? pltd_pkg::ST_NEXT : pltd_pkg::ST_TEST;
         end
         pltd_pkg::ST_PRIME: begin
            state_in = status.cand_is_two ? pltd_pkg::ST_IDLE : pltd_pkg::ST_NEXT;
         end
         pltd_pkg::ST_NEXT: begin
            state_in = pltd_pkg::ST_TEST;
         end
         default: begin
            state_in = pltd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != pltd_pkg::ST_IDLE);
      unique case (state_ff)
         pltd_pkg::ST_IDLE: begin
            cmd.load = start;
         end
         pltd_pkg::ST_CHECK: begin
            cmd.emit_bad = status.cand_lt2;
            cmd.init_div = ~status.cand_lt2;
         end
         pltd_pkg::ST_TEST: begin
            cmd.rem_start = ~status.div_eq_cand;
         end
         pltd_pkg::ST_DIVIDE: begin
            cmd.rem_step = 1'b1;
         end
         pltd_pkg::ST_REMAIN: begin
            cmd.inc_div = ~status.rem_zero;
         end
         pltd_pkg::ST_PRIME: begin
            cmd.emit_prime = 1'b1;
         end
         pltd_pkg::ST_NEXT: begin
            cmd.dec_cand = 1'b1;
            cmd.init_div = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/pltd_dpath.sv =====
`timescale 1ns / 1ps

module pltd_dpath #(
   parameter int VALUE_WIDTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pltd_pkg::cmd_type                   cmd,
   input  logic [pltd_pkg::FIELD_WIDTH-1:0]    req_limit,
   output pltd_pkg::status_type                status,
   output logic                                rsp_strobe,
   output logic [pltd_pkg::FIELD_WIDTH-1:0]    rsp_prime_value,
   output logic                                rsp_is_last,
   output logic                                rsp_bad_limit
);

   localparam int CNT_W = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0]           cand_ff, cand_in;
   logic [VALUE_WIDTH-1:0]           div_ff, div_in;
   logic [VALUE_WIDTH-1:0]           rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0]           sh_ff, sh_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic                             strobe_ff, strobe_in;
   logic [pltd_pkg::FIELD_WIDTH-1:0] value_ff, value_in;
   logic                             last_ff, last_in;
   logic                             bad_ff, bad_in;

   logic [VALUE_WIDTH:0]             trial;
   logic [VALUE_WIDTH:0]             diff;
   logic                             fits;
   logic [VALUE_WIDTH-1:0]           rem_next;

   // one restoring remainder step per cycle
   assign trial    = {rem_ff, sh_ff[VALUE_WIDTH-1]};
   assign diff     = trial - {1'b0, div_ff};
   assign fits     = (trial >= {1'b0, div_ff});
   assign rem_next = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];

   always_comb begin
      cand_in = cand_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) cand_in = req_limit[VALUE_WIDTH-1:0];
      if (cmd.dec_cand) cand_in = cand_ff - VALUE_WIDTH'(1);
      if (cmd.init_div) div_in = VALUE_WIDTH'(2);
      if (cmd.inc_div) div_in = div_ff + VALUE_WIDTH'(1);
      if (cmd.rem_start) begin
         rem_in = '0;
         sh_in  = cand_ff;
         cnt_in = CNT_W'(VALUE_WIDTH - 1);
      end
      if (cmd.rem_step) begin
         rem_in = rem_next;
         sh_in  = sh_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_comb begin
      strobe_in = cmd.emit_prime | cmd.emit_bad;
      value_in  = cmd.emit_bad ? '0 : (pltd_pkg::FIELD_WIDTH)'(cand_ff);
      last_in   = cmd.emit_bad | status.cand_is_two;
      bad_in    = cmd.emit_bad;
   end

   always_ff @(posedge clock) begin
      cand_ff  <= cand_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      sh_ff    <= sh_in;
      cnt_ff   <= cnt_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      bad_ff   <= bad_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      status.cand_lt2    = (cand_ff < VALUE_WIDTH'(2));
      status.cand_is_two = (cand_ff == VALUE_WIDTH'(2));
      status.div_eq_cand = (div_ff == cand_ff);
      status.rem_zero    = (rem_ff == '0);
      status.rem_last    = (cnt_ff == '0);
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_prime_value = value_ff;
   assign rsp_is_last     = last_ff;
   assign rsp_bad_limit   = bad_ff;

endmodule
